// ===== sv/tftc_pkg.sv =====
`timescale 1ns / 1ps

package tftc_pkg;

    // widths of the stream buses and internal fields
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned TYPE_W    = 3;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 8;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned DIGITS_W  = 32;

    // value type codes
    localparam logic [TYPE_W-1:0] TYPE_TEXT    = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_INTEGER = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_DECIMAL = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_BOOLEAN = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_DATE    = 3'd4;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    // lengths and positions
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd11;
    localparam logic [COUNT_W-1:0] DATE_LEN   = 4'd10;
    localparam logic [COUNT_W-1:0] TRUE_LEN   = 4'd4;
    localparam logic [COUNT_W-1:0] FALSE_LEN  = 4'd5;
    localparam logic [COUNT_W-1:0] DATE_DASH1 = 4'd4;
    localparam logic [COUNT_W-1:0] DATE_DASH2 = 4'd7;

    // letters of "true" by position
    function automatic logic [CHAR_W-1:0] true_char(input logic [1:0] idx);
        logic [CHAR_W-1:0] ch;
        case (idx)
            2'd0:    ch = "t";
            2'd1:    ch = "r";
            2'd2:    ch = "u";
            default: ch = "e";
        endcase
        return ch;
    endfunction

    // letters of "false" by position, positions past the word give a dummy
    function automatic logic [CHAR_W-1:0] false_char(input logic [COUNT_W-1:0] idx);
        logic [CHAR_W-1:0] ch;
        case (idx)
            4'd0:    ch = "f";
            4'd1:    ch = "a";
            4'd2:    ch = "l";
            4'd3:    ch = "s";
            4'd4:    ch = "e";
            default: ch = "f";
        endcase
        return ch;
    endfunction

endpackage

// ===== sv/text_field_type_classifier_top.sv =====
`timescale 1ns / 1ps

// text field type classifier
//
// input stream: one beat per byte of a text value. s_axis_tdata carries the
// byte, s_axis_tlast marks the final beat of the value and s_axis_tuser flags
// an empty value (the beat then carries no character). one result beat comes
// out for every input beat with tlast set: m_axis_tdata holds the type code
// (0 text, 1 integer, 2 decimal, 3 boolean, 4 date).
//
// a tlast beat passes the input register, then the result register, before
// m_axis_tvalid rises. throughput: one beat per cycle, but a value end waits
// in the input register while the previous result is untaken; set by the
// combinational flag update between the two registers.
//
// reset (aresetn low, synchronous) empties both registers and returns all
// running flags to the start of a fresh value.
//
// when the receiver stalls, the result register holds its beat; beats that
// do not end a value still flow, and the input side stalls only when a
// second result is ready while the first has not been taken.
module text_field_type_classifier_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [tftc_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [7:0] char_code
    input  logic                           s_axis_tlast,  // last_char
    input  logic                           s_axis_tuser,  // [0] empty_value
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [tftc_pkg::M_TDATA_W-1:0] m_axis_tdata   // [2:0] value_type, [7:3] zero
);
    import tftc_pkg::*;

    // input register
    logic                in_valid_reg;
    logic [CHAR_W-1:0]   in_char_reg;
    logic                in_last_reg;
    logic                in_empty_reg;

    // running state of the value being read
    logic [COUNT_W-1:0]  count_reg,     count_next;
    logic                numeric_reg,   numeric_next;
    logic                point_reg,     point_next;
    logic                body_reg,      body_next;
    logic                true_reg,      true_next;
    logic                false_reg,     false_next;
    logic                shape_reg,     shape_next;
    logic [DIGITS_W-1:0] digits_reg,    digits_next;

    // result register
    logic                out_valid_reg;
    logic [TYPE_W-1:0]   out_type_reg,  out_type_next;

    logic advance;
    logic sign_lead;
    logic is_digit;

    // date decode
    logic [3:0] y3, y2, y1, y0, m1, m0, d1, d0;
    logic       month_ok;
    logic [4:0] month_num;
    logic [6:0] day_num;
    logic [4:0] day_limit;
    logic       low_div4, cent_div4, hundred, leap;
    logic       date_ok;

    // the input register moves on unless it holds a value end whose result
    // has nowhere to go
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-TYPE_W){1'b0}}, out_type_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_char_reg  <= s_axis_tdata[CHAR_W-1:0];
            in_last_reg  <= s_axis_tlast;
            in_empty_reg <= s_axis_tuser;
        end
    end

    // per-character flag update
    always_comb begin
        sign_lead = (count_reg == '0) &&
                    (in_char_reg == CHAR_PLUS || in_char_reg == CHAR_MINUS);
        is_digit  = (in_char_reg >= CHAR_ZERO) && (in_char_reg <= CHAR_NINE);

        count_next   = count_reg;
        numeric_next = numeric_reg;
        point_next   = point_reg;
        body_next    = body_reg;
        true_next    = true_reg;
        false_next   = false_reg;
        shape_next   = shape_reg;
        digits_next  = digits_reg;

        if (!in_empty_reg) begin
            if (!sign_lead) begin
                body_next = 1'b1;
                if (in_char_reg == CHAR_POINT) begin
                    if (point_reg) begin
                        numeric_next = 1'b0;
                    end
                    point_next = 1'b1;
                end else if (!is_digit) begin
                    numeric_next = 1'b0;
                end
            end

            if (count_reg >= TRUE_LEN || in_char_reg != true_char(count_reg[1:0])) begin
                true_next = 1'b0;
            end
            if (count_reg >= FALSE_LEN || in_char_reg != false_char(count_reg)) begin
                false_next = 1'b0;
            end

            if (count_reg >= DATE_LEN) begin
                shape_next = 1'b0;
            end else if (count_reg == DATE_DASH1 || count_reg == DATE_DASH2) begin
                if (in_char_reg != CHAR_MINUS) begin
                    shape_next = 1'b0;
                end
            end else if (is_digit) begin
                // low nibble of an ascii digit is its value
                digits_next = {digits_reg[DIGITS_W-5:0], in_char_reg[3:0]};
            end else begin
                shape_next = 1'b0;
            end

            if (count_reg < COUNT_MAX) begin
                count_next = count_reg + 4'd1;
            end
        end
    end

    // date check on the updated digits
    always_comb begin
        {y3, y2, y1, y0, m1, m0, d1, d0} = digits_next;

        month_ok  = (m1 == 4'd0 && m0 != 4'd0) || (m1 == 4'd1 && m0 <= 4'd2);
        month_num = (m1 == 4'd0) ? {1'b0, m0} : ({1'b0, m0} + 5'd10);
        day_num   = {d1, 3'b000} + {2'b00, d1, 1'b0} + {3'b000, d0};

        // a two-digit number divides by 4 when: tens even and ones 0/4/8,
        // or tens odd and ones 2/6
        low_div4  = y1[0] ? (y0 == 4'd2 || y0 == 4'd6)
                          : (y0 == 4'd0 || y0 == 4'd4 || y0 == 4'd8);
        cent_div4 = y3[0] ? (y2 == 4'd2 || y2 == 4'd6)
                          : (y2 == 4'd0 || y2 == 4'd4 || y2 == 4'd8);
        hundred   = (y1 == 4'd0) && (y0 == 4'd0);
        leap      = hundred ? cent_div4 : low_div4;

        case (month_num)
            5'd2:                      day_limit = leap ? 5'd29 : 5'd28;
            5'd4, 5'd6, 5'd9, 5'd11:   day_limit = 5'd30;
            default:                   day_limit = 5'd31;
        endcase

        date_ok = shape_next && (count_next == DATE_LEN) && month_ok &&
                  (day_num != 7'd0) && (day_num <= {2'b00, day_limit});
    end

    // priority: decimal, boolean, integer, date, text
    always_comb begin
        if (numeric_next && point_next && body_next) begin
            out_type_next = TYPE_DECIMAL;
        end else if ((true_next && count_next == TRUE_LEN) ||
                     (false_next && count_next == FALSE_LEN)) begin
            out_type_next = TYPE_BOOLEAN;
        end else if (numeric_next && body_next && !point_next) begin
            out_type_next = TYPE_INTEGER;
        end else if (date_ok) begin
            out_type_next = TYPE_DATE;
        end else begin
            out_type_next = TYPE_TEXT;
        end
    end

    // running state: back to a fresh value after every value end
    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && in_last_reg)) begin
            count_reg   <= '0;
            numeric_reg <= 1'b1;
            point_reg   <= 1'b0;
            body_reg    <= 1'b0;
            true_reg    <= 1'b1;
            false_reg   <= 1'b1;
            shape_reg   <= 1'b1;
            digits_reg  <= '0;
        end else if (advance) begin
            count_reg   <= count_next;
            numeric_reg <= numeric_next;
            point_reg   <= point_next;
            body_reg    <= body_next;
            true_reg    <= true_next;
            false_reg   <= false_next;
            shape_reg   <= shape_next;
            digits_reg  <= digits_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_type_reg <= out_type_next;
        end
    end

endmodule

// ===== sv/tftc_checker.sv =====
`timescale 1ns / 1ps

module tftc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           s_axis_tlast,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [tftc_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import tftc_pkg::*;

    logic s_beat;
    assign s_beat = s_axis_tvalid && s_axis_tready;

    // no result beat straight after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // type code is one of the defined ones, upper bits zero
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata <= {{(M_TDATA_W-TYPE_W){1'b0}}, TYPE_DATE})
        else $error("result type code out of range");

    // a fresh result follows an accepted value end
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(s_beat && s_axis_tlast, 2))
        else $error("result without a value end");

    // a free output side never blocks the input side
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output ready");

endmodule

bind text_field_type_classifier_top tftc_checker u_tftc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
